// ===== design/go_back_n_sender_unit_assert.svh =====
// Assertion macros for the go-back-n sender unit.
`ifndef GO_BACK_N_SENDER_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBN_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define GBN_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("assertion failed");
`else
`define GBN_ASSERT_IMPL(label, clk, rst_n, prop)
`define GBN_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ===== design/gbn_pkg.sv =====
// Shared types and constants of the go-back-n sender.
package gbn_pkg;
    localparam logic [1:0] OP_MSG  = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [3:0] ST_SENT     = 4'd0;
    localparam logic [3:0] ST_BUFFERED = 4'd1;
    localparam logic [3:0] ST_DROPPED  = 4'd2;
    localparam logic [3:0] ST_EMPTY    = 4'd3;
    localparam logic [3:0] ST_CORRUPT  = 4'd4;
    localparam logic [3:0] ST_DUP      = 4'd5;
    localparam logic [3:0] ST_ACCEPTED = 4'd6;
    localparam logic [3:0] ST_TIMEOUT  = 4'd7;
    localparam logic [3:0] ST_IDLE     = 4'd8;

    // one window entry
    typedef struct packed {
        logic [2:0]  seq;
        logic [63:0] payload;
        logic [31:0] stamp;
    } entry_t;

    // command from the sequencer to each window cell
    typedef struct packed {
        logic        shift;   // take neighbor's entry
        logic        load;    // tail cell loads new entry
        logic        restamp; // stamp with current tick
        logic [31:0] tick;
    } cell_ctl_t;

    // cut payload at first zero byte
    function automatic logic [63:0] clean(input logic [63:0] raw);
        logic [63:0] r;
        logic        stop;
        r = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (raw[8*i +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                r[8*i +: 8] = raw[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic [10:0] bsum(input logic [63:0] p);
        logic [10:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
            s = s + {3'd0, p[8*i +: 8]};
        return s;
    endfunction
endpackage

// ===== design/gbn_cell.sv =====
// One window cell: holds an entry and shifts toward the head.
module gbn_cell
(
    input  logic              clk,
    input  gbn_pkg::cell_ctl_t ctl,
    input  logic              is_tail,
    input  gbn_pkg::entry_t   nbr,
    input  gbn_pkg::entry_t   new_entry,
    output gbn_pkg::entry_t   q
);
    gbn_pkg::entry_t q_reg;
    assign q = q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load && is_tail)
            q_reg <= new_entry;
        else if (ctl.shift)
            q_reg <= nbr;
        else if (ctl.restamp)
            q_reg.stamp <= ctl.tick;
    end
endmodule

// ===== design/go_back_n_sender_unit.sv =====
// Go-back-n sender: window held in a shifting row of cells, overflow FIFO in memory.
// An accepted item is registered and decoded in S_DEC; its first result is then registered
// into the output register. One item at a time: a new item is taken only in the idle state, so
// an ack or a resend holds the input until its results and refills are through; output stalls add to that.
// Reset (rst_n, async low): counters, timer and control cleared, timeout set to 20.
module go_back_n_sender_unit #(
    parameter int WINDOW_SIZE  = 7,
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], msg_payload[65:2], ack_seq_num[97:66], ack_ack_num[129:98],
    // ack_checksum[161:130], ack_payload[225:162], zero fill to 232
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[3:0], pkt_valid[4], seq_num[7:5], pkt_checksum[19:8], pkt_payload[83:20]
    output logic [87:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    localparam int WW = $clog2(WINDOW_SIZE + 1);
    localparam int BW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_REFILL = 3'd3;
    localparam logic [2:0] S_RESEND = 3'd4;
    localparam logic [2:0] S_ONE    = 3'd5;
    localparam logic [2:0] S_TIMER  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [15:0] timeout_reg;
    logic [2:0]  next_seq_reg;
    logic [WW-1:0] win_count_reg;
    logic [BW-1:0] buf_head_reg;
    logic [CW-1:0] buf_count_reg;
    logic [31:0] tick_reg;
    logic        timer_run_reg;
    logic [15:0] timer_left_reg;
    logic [231:0] in_reg;
    logic [WW-1:0] idx_reg;   // resend index or entries left to release
    logic        any_reg;     // refill emitted something
    logic        out_v_reg;
    logic [87:0] out_d_reg;
    logic        out_l_reg;

    logic [1:0]  in_op;
    logic [63:0] in_msg, in_ackpl;
    logic [31:0] in_aseq, in_anum, in_acks;
    assign in_op    = in_reg[1:0];
    assign in_msg   = in_reg[65:2];
    assign in_aseq  = in_reg[97:66];
    assign in_anum  = in_reg[129:98];
    assign in_acks  = in_reg[161:130];
    assign in_ackpl = in_reg[225:162];

    // window cell row; cell 0 is the oldest entry
    gbn_pkg::entry_t   cq [WINDOW_SIZE];
    gbn_pkg::entry_t   new_entry;
    gbn_pkg::cell_ctl_t ctl;
    genvar g;
    generate
        for (g = 0; g < WINDOW_SIZE; g++)
        begin : g_cell
            gbn_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .is_tail  (ctl.shift ? (win_count_reg == WW'(g + 1))
                                     : (win_count_reg == WW'(g))),
                .nbr      (cq[(g + 1) % WINDOW_SIZE]),
                .new_entry(new_entry),
                .q        (cq[g])
            );
        end
    endgenerate

    // overflow FIFO memory
    logic [66:0] buf_mem [BUFFER_DEPTH];
    logic [66:0] buf_rd_reg;
    logic        buf_we;
    logic [BW-1:0] buf_wa;
    logic [BW-1:0] buf_ra;
    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_wa] <= {next_seq_reg, gbn_pkg::clean(in_msg)};
        buf_rd_reg <= buf_mem[buf_ra];
    end

    // match search over cells (independent compares)
    logic          found;
    logic [WW-1:0] found_idx;
    always_comb
    begin
        found = 1'b0;
        found_idx = '0;
        for (int i = WINDOW_SIZE - 1; i >= 0; i--)
            if (WW'(i) < win_count_reg && {29'd0, cq[i].seq} == in_anum)
            begin
                found = 1'b1;
                found_idx = WW'(i);
            end
    end

    logic [31:0] ack_sum;
    assign ack_sum = {21'd0, gbn_pkg::bsum(gbn_pkg::clean(in_ackpl))} + in_anum + in_aseq;

    function automatic logic [87:0] pack_pkt(input logic [3:0] st, input logic [2:0] sq,
                                              input logic [63:0] pl);
        logic [11:0] ck;
        ck = 12'(gbn_pkg::bsum(pl)) + {9'd0, sq} - 12'd1;
        return {4'd0, pl, ck, sq, 1'b1, st};
    endfunction

    logic [15:0] to_eff;
    assign to_eff = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    logic [31:0] elapsed;
    assign elapsed = tick_reg - cq[0].stamp;

    logic out_free;
    assign out_free = !out_v_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tlast  = out_l_reg;
    logic buf_nonempty;
    assign buf_nonempty = buf_count_reg != '0;
    logic [BW-1:0] buf_tail;
    always_comb
    begin
        if ({1'b0, buf_head_reg} + CW'(buf_count_reg) >= CW'(BUFFER_DEPTH))
            buf_tail = BW'({1'b0, buf_head_reg} + CW'(buf_count_reg) - CW'(BUFFER_DEPTH));
        else
            buf_tail = BW'({1'b0, buf_head_reg} + CW'(buf_count_reg));
    end

    // next-state and datapath control
    logic         emit;
    logic [87:0]  emit_d;
    logic         emit_l;
    always_comb
    begin
        state_next = state_reg;
        emit = 1'b0;
        emit_d = '0;
        emit_l = 1'b0;
        ctl = '0;
        ctl.tick = tick_reg;
        new_entry = '0;
        buf_we = 1'b0;
        buf_wa = buf_tail;
        buf_ra = buf_head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    emit = 1'b1;
                    emit_l = 1'b1;
                    emit_d = {84'd0, gbn_pkg::ST_IDLE};
                    priority if (in_op == gbn_pkg::OP_MSG)
                    begin
                        if (win_count_reg < WW'(WINDOW_SIZE))
                        begin
                            new_entry = '{next_seq_reg, gbn_pkg::clean(in_msg), tick_reg};
                            ctl.load = 1'b1;
                            emit_d = pack_pkt(gbn_pkg::ST_SENT, next_seq_reg,
                                              gbn_pkg::clean(in_msg));
                        end
                        else if (buf_count_reg < CW'(BUFFER_DEPTH))
                        begin
                            buf_we = 1'b1;
                            emit_d = {84'd0, gbn_pkg::ST_BUFFERED};
                        end
                        else
                            emit_d = {84'd0, gbn_pkg::ST_DROPPED};
                    end
                    else if (in_op == gbn_pkg::OP_ACK)
                    begin
                        if (win_count_reg == '0)
                            emit_d = {84'd0, gbn_pkg::ST_EMPTY};
                        else if (ack_sum != in_acks)
                            emit_d = {84'd0, gbn_pkg::ST_CORRUPT};
                        else
                        begin
                            emit = 1'b0;
                            state_next = found ? S_SHIFT : S_RESEND;
                        end
                    end
                    else if (in_op == gbn_pkg::OP_TICK)
                    begin
                        if (timer_run_reg && timer_left_reg <= 16'd1 && win_count_reg != '0)
                        begin
                            emit = 1'b0;
                            state_next = S_RESEND;
                        end
                    end
                    else
                        // unknown op: idle status only
                        emit_d = {84'd0, gbn_pkg::ST_IDLE};
                end
            end
            S_SHIFT:
            begin
                ctl.shift = 1'b1;
                if (idx_reg == '0)
                    state_next = S_REFILL;
            end
            S_REFILL:
            begin
                if (win_count_reg < WW'(WINDOW_SIZE) && buf_nonempty)
                    state_next = S_ONE;
                else if (out_free)
                begin
                    state_next = S_TIMER;
                    if (!any_reg)
                    begin
                        emit = 1'b1;
                        emit_l = 1'b1;
                        emit_d = {84'd0, gbn_pkg::ST_ACCEPTED};
                    end
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    new_entry = '{buf_rd_reg[66:64], buf_rd_reg[63:0], tick_reg};
                    ctl.load = 1'b1;
                    emit = 1'b1;
                    emit_d = pack_pkt(gbn_pkg::ST_ACCEPTED, buf_rd_reg[66:64],
                                      buf_rd_reg[63:0]);
                    emit_l = !(win_count_reg + 1'b1 < WW'(WINDOW_SIZE)
                               && buf_count_reg > CW'(1));
                    state_next = S_REFILL;
                end
            end
            S_TIMER:
            begin
                state_next = S_IDLE;
            end
            S_RESEND:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_d = pack_pkt((in_op == gbn_pkg::OP_ACK) ? gbn_pkg::ST_DUP
                                                              : gbn_pkg::ST_TIMEOUT,
                                      cq[0].seq, cq[0].payload);
                    emit_l = (idx_reg == win_count_reg - 1'b1);
                    // rotate: head goes to tail with a fresh stamp
                    ctl.shift = 1'b1;
                    ctl.load = 1'b1;
                    new_entry = '{cq[0].seq, cq[0].payload, tick_reg};
                    if (emit_l)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // rotation must land at tail of full count: tail index during rotate
    // is win_count-1 (is_tail compares with shift adjust)

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            timeout_reg    <= 16'd20;
            next_seq_reg   <= '0;
            win_count_reg  <= '0;
            buf_head_reg   <= '0;
            buf_count_reg  <= '0;
            tick_reg       <= '0;
            timer_run_reg  <= 1'b0;
            timer_left_reg <= '0;
            idx_reg        <= '0;
            any_reg        <= 1'b0;
            out_v_reg      <= 1'b0;
            out_l_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
            if (emit)
            begin
                out_v_reg <= 1'b1;
                out_l_reg <= emit_l;
            end
            else if (m_tready)
                out_v_reg <= 1'b0;
            if (state_reg == S_IDLE && s_tvalid)
                in_reg <= s_tdata;
            if (state_reg == S_DEC && out_free)
            begin
                idx_reg <= '0;
                any_reg <= 1'b0;
                if (in_op == gbn_pkg::OP_MSG)
                begin
                    if (win_count_reg < WW'(WINDOW_SIZE))
                    begin
                        win_count_reg <= win_count_reg + 1'b1;
                        next_seq_reg <= next_seq_reg + 3'd1;
                        if (win_count_reg == '0)
                        begin
                            timer_run_reg <= 1'b1;
                            timer_left_reg <= to_eff;
                        end
                    end
                    else if (buf_count_reg < CW'(BUFFER_DEPTH))
                    begin
                        buf_count_reg <= buf_count_reg + 1'b1;
                        next_seq_reg <= next_seq_reg + 3'd1;
                    end
                end
                else if (in_op == gbn_pkg::OP_ACK)
                    idx_reg <= found_idx;
                else if (in_op == gbn_pkg::OP_TICK)
                begin
                    tick_reg <= tick_reg + 32'd1;
                    if (timer_run_reg)
                    begin
                        if (timer_left_reg <= 16'd1)
                        begin
                            if (win_count_reg == '0)
                            begin
                                timer_run_reg <= 1'b0;
                                timer_left_reg <= '0;
                            end
                            else
                                timer_left_reg <= to_eff;
                        end
                        else
                            timer_left_reg <= timer_left_reg - 16'd1;
                    end
                end
            end
            if (state_reg == S_SHIFT)
            begin
                win_count_reg <= win_count_reg - 1'b1;
                idx_reg <= idx_reg - 1'b1;
            end
            if (state_reg == S_ONE && out_free)
            begin
                any_reg <= 1'b1;
                win_count_reg <= win_count_reg + 1'b1;
                buf_count_reg <= buf_count_reg - 1'b1;
                buf_head_reg <= (buf_head_reg == BW'(BUFFER_DEPTH - 1)) ? '0
                                : buf_head_reg + 1'b1;
            end
            if (state_reg == S_REFILL && state_next == S_TIMER)
            begin
                if (win_count_reg == '0)
                begin
                    timer_run_reg <= 1'b0;
                    timer_left_reg <= '0;
                end
            end
            if (state_reg == S_TIMER && win_count_reg != '0)
            begin
                timer_run_reg <= 1'b1;
                if (elapsed >= {16'd0, timeout_reg})
                    timer_left_reg <= 16'd1;
                else
                    timer_left_reg <= timeout_reg - elapsed[15:0];
            end
            if (state_reg == S_RESEND && out_free)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (emit_l)
                begin
                    timer_run_reg <= 1'b1;
                    timer_left_reg <= to_eff;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_d_reg <= emit_d;
    end

`include "go_back_n_sender_unit_assert.svh"
    `GBN_ASSERT_IMPL(a_win_bound, clk, rst_n, win_count_reg <= WW'(WINDOW_SIZE))
    `GBN_ASSERT_IMPL(a_buf_bound, clk, rst_n, buf_count_reg <= CW'(BUFFER_DEPTH))
    `GBN_ASSERT_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)
endmodule
